// ===== hdl/hsa_pkg.sv =====
package hsa_pkg;

  // Channel and fixed-point widths
  localparam int CH_W    = 8;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 12;
  localparam int CQ_W    = CH_W + FRAC_W;        // chroma in Q12, capped at max << 12
  localparam int PROD_W  = CH_W + GAIN_W;        // delta * gain before the cap
  localparam int NUM_W   = CQ_W + CH_W;          // chroma * (mid - min)
  localparam int NUM_CH  = 3;

  // One quotient bit per cell; the quotient never exceeds the chroma for a non-zero divisor
  localparam int DIV_STEPS = CQ_W;

  // Registers from accept to the result strobe: four front stages,
  // the division row and the output register
  localparam int PIPE_STAGES = 4 + DIV_STEPS + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // Role of a channel within its pixel
  localparam logic [1:0] SEL_MID = 2'd0;
  localparam logic [1:0] SEL_MIN = 2'd1;
  localparam logic [1:0] SEL_MAX = 2'd2;

  // Per-pixel data that rides alongside the division
  typedef struct packed {
    logic [CQ_W-1:0]              base;   // (max << 12) - chroma
    logic [CH_W-1:0]              mx;
    logic [NUM_CH-1:0][1:0]       sel;    // [0] red, [1] green, [2] blue
  } side_t;

  // Contents of one division cell
  typedef struct packed {
    logic                         valid;
    logic [CH_W-1:0]              rem;    // partial remainder, below the divisor
    logic [DIV_STEPS-1:0]         nq;     // dividend bits out at the top, quotient in below
    logic [CH_W-1:0]              dvs;    // divisor: channel delta
    side_t                        side;
  } cell_t;

endpackage

// ===== hdl/hsa_front.sv =====
module hsa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hsa_pkg::CH_W-1:0]     in_red,
  input  logic [hsa_pkg::CH_W-1:0]     in_green,
  input  logic [hsa_pkg::CH_W-1:0]     in_blue,
  input  logic                         cfg_wr_en,
  input  logic [hsa_pkg::GAIN_W-1:0]   cfg_wr_data,
  output hsa_pkg::cell_t               head
);

  logic [hsa_pkg::GAIN_W-1:0] sat_gain;

  // stage A: extremes, middle value and channel roles
  logic                                      a_valid;
  logic [hsa_pkg::CH_W-1:0]                  a_mx;
  logic [hsa_pkg::CH_W-1:0]                  a_d;
  logic [hsa_pkg::CH_W-1:0]                  a_span;
  logic [hsa_pkg::NUM_CH-1:0][1:0]           a_sel;

  // stage B: raw chroma product
  logic                                      b_valid;
  logic [hsa_pkg::PROD_W-1:0]                b_prod;
  logic [hsa_pkg::CH_W-1:0]                  b_mx;
  logic [hsa_pkg::CH_W-1:0]                  b_d;
  logic [hsa_pkg::CH_W-1:0]                  b_span;
  logic [hsa_pkg::NUM_CH-1:0][1:0]           b_sel;

  // stage C: capped chroma and base
  logic                                      c_valid;
  logic [hsa_pkg::CQ_W-1:0]                  c_cq;
  logic [hsa_pkg::CQ_W-1:0]                  c_base;
  logic [hsa_pkg::CH_W-1:0]                  c_mx;
  logic [hsa_pkg::CH_W-1:0]                  c_d;
  logic [hsa_pkg::CH_W-1:0]                  c_span;
  logic [hsa_pkg::NUM_CH-1:0][1:0]           c_sel;

  logic [hsa_pkg::CH_W-1:0]                  mx_next;
  logic [hsa_pkg::CH_W-1:0]                  mn_next;
  logic [hsa_pkg::CH_W-1:0]                  mid_next;
  logic [hsa_pkg::NUM_CH-1:0][1:0]           sel_next;
  logic [hsa_pkg::CQ_W-1:0]                  cap;
  logic [hsa_pkg::CQ_W-1:0]                  cq_next;
  logic [hsa_pkg::NUM_W-1:0]                 num_next;

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_gain <= hsa_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      sat_gain <= cfg_wr_data;
    end
  end

  // channel extremes; the middle value is the sum less max and min
  always_comb begin
    logic [hsa_pkg::CH_W-1:0]   ch [hsa_pkg::NUM_CH];
    logic [hsa_pkg::CH_W+1:0]   sum;
    ch[0] = in_red;
    ch[1] = in_green;
    ch[2] = in_blue;
    mx_next = in_red;
    mn_next = in_red;
    if (in_green > mx_next) mx_next = in_green;
    if (in_blue  > mx_next) mx_next = in_blue;
    if (in_green < mn_next) mn_next = in_green;
    if (in_blue  < mn_next) mn_next = in_blue;
    sum = {2'b0, in_red} + {2'b0, in_green} + {2'b0, in_blue}
          - {2'b0, mx_next} - {2'b0, mn_next};
    mid_next = sum[hsa_pkg::CH_W-1:0];
    for (int i = 0; i < hsa_pkg::NUM_CH; i++) begin
      priority if (ch[i] == mx_next) begin
        sel_next[i] = hsa_pkg::SEL_MAX;
      end else if (ch[i] == mn_next) begin
        sel_next[i] = hsa_pkg::SEL_MIN;
      end else begin
        sel_next[i] = hsa_pkg::SEL_MID;
      end
    end
  end

  // chroma cap and numerator of the middle channel
  always_comb begin
    cap = {b_mx, hsa_pkg::FRAC_W'(0)};
    if (b_prod > {{(hsa_pkg::PROD_W-hsa_pkg::CQ_W){1'b0}}, cap}) begin
      cq_next = cap;
    end else begin
      cq_next = b_prod[hsa_pkg::CQ_W-1:0];
    end
    num_next = {{hsa_pkg::CH_W{1'b0}}, c_cq} * {{hsa_pkg::CQ_W{1'b0}}, c_span};
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      head.valid <= 1'b0;
    end else begin
      a_valid    <= start;
      b_valid    <= a_valid;
      c_valid    <= b_valid;
      head.valid <= c_valid;
    end

    a_mx    <= mx_next;
    a_d     <= mx_next - mn_next;
    a_span  <= mid_next - mn_next;
    a_sel   <= sel_next;

    b_prod  <= {{hsa_pkg::GAIN_W{1'b0}}, a_d} * {{hsa_pkg::CH_W{1'b0}}, sat_gain};
    b_mx    <= a_mx;
    b_d     <= a_d;
    b_span  <= a_span;
    b_sel   <= a_sel;

    c_cq    <= cq_next;
    c_base  <= cap - cq_next;
    c_mx    <= b_mx;
    c_d     <= b_d;
    c_span  <= b_span;
    c_sel   <= b_sel;

    // top bits of the numerator are already below the divisor
    head.rem       <= num_next[hsa_pkg::NUM_W-1:hsa_pkg::DIV_STEPS];
    head.nq        <= num_next[hsa_pkg::DIV_STEPS-1:0];
    head.dvs       <= c_d;
    head.side.base <= c_base;
    head.side.mx   <= c_mx;
    head.side.sel  <= c_sel;
  end

endmodule

// ===== hdl/hsa_div_cell.sv =====
module hsa_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  hsa_pkg::cell_t    i_cell,
  output hsa_pkg::cell_t    o_cell
);

  hsa_pkg::cell_t cell_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    logic [hsa_pkg::CH_W:0] trial;
    logic                   fits;
    trial = {i_cell.rem, i_cell.nq[hsa_pkg::DIV_STEPS-1]};
    fits  = (trial >= {1'b0, i_cell.dvs});
    cell_next = i_cell;
    if (fits) begin
      cell_next.rem = hsa_pkg::CH_W'(trial - {1'b0, i_cell.dvs});
    end else begin
      cell_next.rem = trial[hsa_pkg::CH_W-1:0];
    end
    cell_next.nq = {i_cell.nq[hsa_pkg::DIV_STEPS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_cell.valid <= 1'b0;
    end else begin
      o_cell.valid <= cell_next.valid;
    end
    o_cell.rem  <= cell_next.rem;
    o_cell.nq   <= cell_next.nq;
    o_cell.dvs  <= cell_next.dvs;
    o_cell.side <= cell_next.side;
  end

  // partial remainder stays below a non-zero divisor
  assert property (@(posedge clk) disable iff (rst)
    (o_cell.valid && (o_cell.dvs != '0)) |-> (o_cell.rem < o_cell.dvs))
    else $error("division cell remainder not below divisor");

endmodule

// ===== hdl/hsv_saturation_adjust_top.sv =====
// HSV saturation adjust. One RGB pixel is taken on every clock at which start
// is high and busy is low; busy is high only while rst is held, so a pixel can
// be offered on every cycle and the sustained rate is one pixel per clock. Each
// pixel comes back on out_red/out_green/out_blue through the registers listed
// below, marked by done for a single cycle, in order of entry. The
// receiver cannot stall and must take every result on the cycle it appears.
// The path runs through four front stages (extremes, gain multiply, chroma cap,
// numerator multiply), a row of 20 division cells that each resolve one
// quotient bit of the middle channel, and the output register. sat_gain
// (unsigned Q4.12, 4096 = 1.0 after reset) is written through cfg_wr_en and
// cfg_wr_data, and should only change while no pixel is in flight.
module hsv_saturation_adjust_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [hsa_pkg::CH_W-1:0]     in_red,
  input  logic [hsa_pkg::CH_W-1:0]     in_green,
  input  logic [hsa_pkg::CH_W-1:0]     in_blue,
  input  logic                         cfg_wr_en,
  input  logic [hsa_pkg::GAIN_W-1:0]   cfg_wr_data,
  output logic                         done,
  output logic [hsa_pkg::CH_W-1:0]     out_red,
  output logic [hsa_pkg::CH_W-1:0]     out_green,
  output logic [hsa_pkg::CH_W-1:0]     out_blue
);

  hsa_pkg::cell_t                  chain [hsa_pkg::DIV_STEPS+1];
  hsa_pkg::cell_t                  tail;
  logic [hsa_pkg::CQ_W:0]          mid_sum;
  logic [hsa_pkg::CH_W-1:0]        mid_val;
  logic [hsa_pkg::CH_W-1:0]        min_val;
  logic [hsa_pkg::NUM_CH-1:0][hsa_pkg::CH_W-1:0] res_next;

  assign busy = rst;

  // front stages
  hsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (chain[0])
  );

  // division row, one quotient bit per cell
  for (genvar k = 0; k < hsa_pkg::DIV_STEPS; k++) begin : g_div
    hsa_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .i_cell (chain[k]),
      .o_cell (chain[k+1])
    );
  end

  assign tail = chain[hsa_pkg::DIV_STEPS];

  // channel results by role
  always_comb begin
    mid_sum = {1'b0, tail.side.base} + {1'b0, tail.nq};
    mid_val = mid_sum[hsa_pkg::CQ_W-1:hsa_pkg::FRAC_W];
    min_val = tail.side.base[hsa_pkg::CQ_W-1:hsa_pkg::FRAC_W];
    for (int i = 0; i < hsa_pkg::NUM_CH; i++) begin
      unique case (tail.side.sel[i])
        hsa_pkg::SEL_MAX: res_next[i] = tail.side.mx;
        hsa_pkg::SEL_MIN: res_next[i] = min_val;
        hsa_pkg::SEL_MID: res_next[i] = mid_val;
        default:          res_next[i] = tail.side.mx;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= res_next[0];
    out_green <= res_next[1];
    out_blue  <= res_next[2];
  end

  // every accepted pixel raises the strobe after passing all pipeline registers
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hsa_pkg::PIPE_STAGES) done)
    else $error("result strobe missing after fixed latency");

  // no strobe without a matching transaction
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hsa_pkg::PIPE_STAGES))
    else $error("result strobe without an accepted transaction");

  // middle channel never exceeds the pixel maximum
  assert property (@(posedge clk) disable iff (rst)
    (tail.valid && (tail.dvs != '0)) |->
      (mid_sum <= {1'b0, tail.side.mx, hsa_pkg::FRAC_W'(0)}))
    else $error("middle channel above pixel maximum");

endmodule
